[hw/rtl/avt_pkg.sv]
// avt_pkg: shared types and constants for the expiring avoid table.
// Used by avt_scan and expiring_avoid_table_core; no dependencies.
package avt_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int GOAL_W = 16;
    localparam int TIME_W = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] OP_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] OP_QUERY = 2'd2;

    // One table entry as held in memory
    typedef struct packed {
        logic [GOAL_W-1:0] goal;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Request handed from the top level to the scanner
    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [GOAL_W-1:0] goal;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] new_expiry;
    } t_req;

    // Result word
    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic              found;
        logic              stored;
    } t_res;

    // Scanner sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

[hw/rtl/expiring_avoid_table_core.sv]
// expiring_avoid_table_core: top level of the expiring avoid table.
// Depends on avt_pkg, avt_ram and avt_scan.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one word: i_func (0 clear, 1 add,
//   2 query), i_goal_number, i_now_time and i_avoid_duration. Output channel
//   (o_valid / i_ready) returns one word per input: o_remaining_time, o_found,
//   o_stored.
//   The table lives in a 64-entry RAM with a registered read port. Add and query
//   walk it from entry 0, one entry per cycle, and stop at the first hit.
//   A clear or an unused code skips the walk and goes straight to the hand-off.
//   A new word is accepted only while the scanner is idle, so it waits until the
//   previous word's result has been loaded into the output register.
//   A clear takes effect at once through per-entry valid bits; no RAM sweep.
//   The result sits in an output register, so a new word is taken while the
//   previous result waits. If the receiver stalls and the output register is
//   still full when a scan finishes, the scanner holds and o_ready stays low.
//   Reset empties the table (all entries read as goal 0, expiry 0) and drops
//   any pending result.
module expiring_avoid_table_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [avt_pkg::FUNC_W-1:0]   i_func,
    input  logic [avt_pkg::GOAL_W-1:0]   i_goal_number,
    input  logic [avt_pkg::TIME_W-1:0]   i_now_time,
    input  logic [avt_pkg::TIME_W-1:0]   i_avoid_duration,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [avt_pkg::TIME_W-1:0]   o_remaining_time,
    output logic                         o_found,
    output logic                         o_stored
);
    import avt_pkg::*;

    logic             accept, idle, res_free, res_load;
    logic [TIME_W:0]  exp_sum;
    t_req             req;
    t_res             res;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    t_entry           rd_data, wr_data;
    logic [ENTRY_W-1:0] rd_bits;

    logic r_out_valid;
    t_res r_out;

    assign o_ready = idle;
    assign accept  = i_valid && idle;

    // Saturating expiry for add
    assign exp_sum        = {1'b0, i_now_time} + {1'b0, i_avoid_duration};
    assign req.op         = i_func;
    assign req.goal       = i_goal_number;
    assign req.now        = i_now_time;
    assign req.new_expiry = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

    assign res_free = !r_out_valid || i_ready;

    avt_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_req      (req),
        .o_idle     (idle),
        .i_res_free (res_free),
        .o_res_load (res_load),
        .o_res      (res),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    assign rd_data = t_entry'(rd_bits);

    avt_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_remaining_time = r_out.remaining;
    assign o_found          = r_out.found;
    assign o_stored         = r_out.stored;

endmodule

[hw/rtl/avt_ram.sv]
// avt_ram: simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module avt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[hw/rtl/avt_scan.sv]
// avt_scan: sequencer that walks the table memory one entry per cycle for add and query.
// Depends on avt_pkg; drives the avt_ram ports and holds the per-entry valid bits.
module avt_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  avt_pkg::t_req               i_req,
    output logic                        o_idle,
    input  logic                        i_res_free,
    output logic                        o_res_load,
    output avt_pkg::t_res               o_res,
    output logic                        o_rd_en,
    output logic [avt_pkg::IDX_W-1:0]   o_rd_addr,
    input  avt_pkg::t_entry             i_rd_data,
    output logic                        o_wr_en,
    output logic [avt_pkg::IDX_W-1:0]   o_wr_addr,
    output avt_pkg::t_entry             o_wr_data
);
    import avt_pkg::*;

    t_state                   r_state, n_state;
    t_req                     r_req;
    t_res                     r_res;
    logic [IDX_W-1:0]         r_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;

    t_entry entry;
    logic   hit_add, hit_qry, last, finish;

    // Entry under test: a never-written entry reads as zero
    assign entry   = r_valid[r_idx] ? i_rd_data : '0;
    assign hit_add = (r_req.op == OP_ADD) && (r_req.now > entry.expiry);
    assign hit_qry = (r_req.op == OP_QUERY) && (entry.goal == r_req.goal)
                     && (r_req.now <= entry.expiry);
    assign last    = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign finish  = hit_add || hit_qry || last;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req.op == OP_ADD || i_req.op == OP_QUERY) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: memory requests and result hand-off
    always_comb begin
        o_idle     = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx + 1'b1;
        o_wr_en    = 1'b0;
        o_res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle    = 1'b1;
                o_rd_en   = i_start;
                o_rd_addr = '0;
            end
            S_SCAN: begin
                o_rd_en = !finish;
                o_wr_en = hit_add;
            end
            S_DONE: begin
                o_res_load = i_res_free;
            end
            default: ;
        endcase
    end

    assign o_wr_addr        = r_idx;
    assign o_wr_data.goal   = r_req.goal;
    assign o_wr_data.expiry = r_req.new_expiry;
    assign o_res            = r_res;

    // Control state: sequencer and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start && i_req.op == OP_CLEAR) begin
                r_valid <= '0;
            end else if (o_wr_en) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    // Request, scan index and result
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_req <= i_req;
            r_idx <= '0;
            r_res <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + 1'b1;
            if (hit_add) begin
                r_res.stored <= 1'b1;
            end
            if (hit_qry) begin
                r_res.found     <= 1'b1;
                r_res.remaining <= entry.expiry - r_req.now;
            end
        end
    end

    // Scan only runs after a read was issued the cycle before
    a_scan_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> $past(o_rd_en))
        else $error("scan cycle without a preceding memory read");

    // Memory is written only during a scan, and only for add
    a_write_in_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_SCAN && r_req.op == OP_ADD))
        else $error("table write outside an add scan");

    // A write ends the scan
    a_write_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_state == S_DONE && r_res.stored))
        else $error("add write did not finish the scan");

    // A delivered result returns the sequencer to idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |=> (r_state == S_IDLE))
        else $error("result hand-off did not return to idle");

endmodule
